// ===== src/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants for residual reconstruction with SSD
// Widths, register indexes, the last-row-per-block table and the per-pixel
// arithmetic helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int MaxRows        = 32;
	localparam int ColumnsPerHalf = 16;
	localparam int RowW           = 5;
	localparam int ColW           = 4;
	localparam int SumW           = 25;
	localparam int TotalW         = SumW + 1;
	localparam int SqW            = 16;

	// Configuration register indexes.
	localparam logic [1:0] REG_COLOR = 2'd0;
	localparam logic [1:0] REG_DEPTH = 2'd1;
	localparam logic [1:0] REG_SIZE  = 2'd2;

	// Configuration codes.
	localparam logic [1:0] COLOR_LUMA  = 2'd0;
	localparam logic [1:0] COLOR_SHORT = 2'd3;
	localparam logic [2:0] DEPTH_TSKIP = 3'd3;

	// Last row index of a block: first index is the short-table select.
	localparam logic [RowW-1:0] ROW_TABLE [2][4] = '{
		'{5'd31, 5'd7, 5'd1, 5'd0},
		'{5'd15, 5'd3, 5'd0, 5'd0}
	};

	localparam logic [RowW-1:0] LAST_ROW_MAX = RowW'(MaxRows - 1);
	localparam logic [ColW-1:0] LAST_COL     = ColW'(ColumnsPerHalf - 1);

	typedef struct packed {
		logic [7:0]     rec_lo;
		logic [7:0]     rec_hi;
		logic [SqW-1:0] sq_lo;
		logic [SqW-1:0] sq_hi;
	} pix_t;

	function automatic logic [7:0] recon(input logic signed [15:0] resid,
			input logic [7:0] pred);
		logic signed [16:0] s;
		s = $signed({resid[15], resid}) + $signed({9'b0, pred});
		priority if (s < 0) begin
			recon = 8'd0;
		end else if (s > 17'sd255) begin
			recon = 8'd255;
		end else begin
			recon = s[7:0];
		end
	endfunction

	function automatic logic [SqW-1:0] square_diff(input logic [7:0] a,
			input logic [7:0] b);
		logic [7:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		square_diff = d * d;
	endfunction

	function automatic logic [RowW-1:0] last_row(input logic short_tab,
			input logic [1:0] size);
		logic [RowW-1:0] r;
		r = ROW_TABLE[short_tab][size];
		last_row = (r > LAST_ROW_MAX) ? LAST_ROW_MAX : r;
	endfunction

endpackage

// ===== src/rrs_in_if.sv =====
// ----------------------------------------------------------------------------
// rrs_in_if: input channel
// Valid/ready channel carrying residual, prediction and reference per half.
// ----------------------------------------------------------------------------
interface rrs_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] resid_lo;
	logic signed [15:0] resid_hi;
	logic [7:0]         pred_lo;
	logic [7:0]         pred_hi;
	logic [7:0]         ref_lo;
	logic [7:0]         ref_hi;

	modport source (output valid, resid_lo, resid_hi, pred_lo, pred_hi, ref_lo,
		ref_hi, input ready);
	modport sink (input valid, resid_lo, resid_hi, pred_lo, pred_hi, ref_lo,
		ref_hi, output ready);
endinterface

// ===== src/rrs_out_if.sv =====
// ----------------------------------------------------------------------------
// rrs_out_if: result channel
// Valid/ready channel carrying reconstructed pixels and running sums.
// ----------------------------------------------------------------------------
interface rrs_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rec_lo;
	logic [7:0]  rec_hi;
	logic [24:0] ssd_lo;
	logic [24:0] ssd_hi;
	logic [25:0] ssd_total;
	logic        block_done;

	modport source (output valid, rec_lo, rec_hi, ssd_lo, ssd_hi, ssd_total,
		block_done, input ready);
	modport sink (input valid, rec_lo, rec_hi, ssd_lo, ssd_hi, ssd_total,
		block_done, output ready);
endinterface

// ===== src/rrs_recon.sv =====
// ----------------------------------------------------------------------------
// rrs_recon: input register and pixel reconstruction stage
// Registers each input beat, then forms clipped pixels and squared errors.
// ----------------------------------------------------------------------------
module rrs_recon (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         ts_mode,
	rrs_in_if.sink       in,
	output logic         s2_valid,
	input  logic         s2_ready,
	output rrs_pkg::pix_t s2_data
);
	import rrs_pkg::*;

	logic               valid_s1;
	logic               ready_s1;
	logic signed [15:0] resid_lo_s1;
	logic signed [15:0] resid_hi_s1;
	logic [7:0]         pred_lo_s1;
	logic [7:0]         pred_hi_s1;
	logic [7:0]         ref_lo_s1;
	logic [7:0]         ref_hi_s1;
	logic               valid_s2;
	pix_t               pix_s2;
	pix_t               pix_d;
	logic [7:0]         pred_up;
	logic [7:0]         ref_up;

	assign ready_s1 = !valid_s1 || s2_ready || !valid_s2;
	assign in.ready = !valid_s1 || (s2_ready || !valid_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			resid_lo_s1 <= in.resid_lo;
			resid_hi_s1 <= in.resid_hi;
			pred_lo_s1  <= in.pred_lo;
			pred_hi_s1  <= in.pred_hi;
			ref_lo_s1   <= in.ref_lo;
			ref_hi_s1   <= in.ref_hi;
		end
	end

	// In transform-skip mode the upper half takes the lower half's pixels.
	always_comb begin
		pred_up       = ts_mode ? pred_lo_s1 : pred_hi_s1;
		ref_up        = ts_mode ? ref_lo_s1 : ref_hi_s1;
		pix_d.rec_lo  = recon(resid_lo_s1, pred_lo_s1);
		pix_d.rec_hi  = recon(resid_hi_s1, pred_up);
		pix_d.sq_lo   = square_diff(ref_lo_s1, pix_d.rec_lo);
		pix_d.sq_hi   = square_diff(ref_up, pix_d.rec_hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready || !valid_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && (s2_ready || !valid_s2)) begin
			pix_s2 <= pix_d;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = pix_s2;

endmodule

// ===== src/rrs_accum.sv =====
// ----------------------------------------------------------------------------
// rrs_accum: block position counters, SSD accumulators and result register
// Adds each squared error into the running sums and marks the block end.
// ----------------------------------------------------------------------------
module rrs_accum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          short_tab,
	input  logic [1:0]    size_index,
	input  logic          s2_valid,
	output logic          s2_ready,
	input  rrs_pkg::pix_t s2_data,
	rrs_out_if.source     out
);
	import rrs_pkg::*;

	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_q;
	logic [SumW-1:0] sum_lo_q;
	logic [SumW-1:0] sum_hi_q;
	logic            out_valid_q;
	logic [7:0]      rec_lo_q;
	logic [7:0]      rec_hi_q;
	logic [SumW-1:0] ssd_lo_q;
	logic [SumW-1:0] ssd_hi_q;
	logic            done_q;
	logic            take;
	logic            row_end;
	logic            block_end;
	logic [SumW-1:0] new_lo;
	logic [SumW-1:0] new_hi;

	assign s2_ready  = !out_valid_q || out.ready;
	assign take      = s2_valid && s2_ready;
	assign row_end   = col_q >= LAST_COL;
	assign block_end = row_end && (row_q >= last_row(short_tab, size_index));
	assign new_lo    = sum_lo_q + SumW'(s2_data.sq_lo);
	assign new_hi    = sum_hi_q + SumW'(s2_data.sq_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			sum_lo_q    <= '0;
			sum_hi_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				out_valid_q <= s2_valid;
			end
			if (take) begin
				if (block_end) begin
					row_q    <= '0;
					col_q    <= '0;
					sum_lo_q <= '0;
					sum_hi_q <= '0;
				end else begin
					sum_lo_q <= new_lo;
					sum_hi_q <= new_hi;
					if (row_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rec_lo_q <= s2_data.rec_lo;
			rec_hi_q <= s2_data.rec_hi;
			ssd_lo_q <= new_lo;
			ssd_hi_q <= new_hi;
			done_q   <= block_end;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.rec_lo     = rec_lo_q;
	assign out.rec_hi     = rec_hi_q;
	assign out.ssd_lo     = ssd_lo_q;
	assign out.ssd_hi     = ssd_hi_q;
	assign out.ssd_total  = {1'b0, ssd_lo_q} + {1'b0, ssd_hi_q};
	assign out.block_done = done_q;

endmodule

// ===== src/residual_reconstruct_ssd_core.sv =====
// ----------------------------------------------------------------------------
// residual_reconstruct_ssd_core: residual reconstruction with SSD
// Top level: configuration registers, reconstruction stage and accumulator.
// ----------------------------------------------------------------------------
// Each input beat carries one column of a block row for a lower and an upper
// half: a signed residual, a prediction pixel and a reference pixel per half.
// The block returns one result beat per input beat with both reconstructed
// pixels (residual plus prediction, clipped to 0..255), the running sums of
// squared reconstruction error for each half over the current block, their
// total, and a block_done flag on the last beat of the block. A row is 16
// beats; the number of rows comes from a table chosen by the colour component
// and the size index, and the sums and counters restart after block_done.
// The block sustains one beat per clock cycle while results are taken: its
// feedback loops are the add of a squared error into each running sum and
// the row and column counters. An accepted beat passes through the input
// register, the pixel stage register and the result register in that order,
// and its result is offered from the result register. A waiting result
// holds the result register; the two stages behind it go on taking beats
// until both are full, so at most three beats are held inside and the input
// is then stalled until the result is taken.
// Configuration registers must be written only while no beats are in flight.
module residual_reconstruct_ssd_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data,
	rrs_in_if.sink     in,
	rrs_out_if.source  out
);
	import rrs_pkg::*;

	logic [1:0] color_q;
	logic [2:0] depth_q;
	logic [1:0] size_q;
	logic       ts_mode;
	logic       short_tab;
	logic       s2_valid;
	logic       s2_ready;
	pix_t       s2_data;

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_LUMA;
			depth_q <= '0;
			size_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR: color_q <= cfg_data[1:0];
				REG_DEPTH: depth_q <= cfg_data;
				REG_SIZE:  size_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Transform skip applies to luma blocks at the matching depth only.
	assign ts_mode   = (color_q == COLOR_LUMA) && (depth_q == DEPTH_TSKIP);
	assign short_tab = (color_q == COLOR_SHORT);

	rrs_recon u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.ts_mode  (ts_mode),
		.in       (in),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2_data  (s2_data)
	);

	rrs_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.short_tab  (short_tab),
		.size_index (size_q),
		.s2_valid   (s2_valid),
		.s2_ready   (s2_ready),
		.s2_data    (s2_data),
		.out        (out)
	);

endmodule

// ===== test/tb_residual_reconstruct_ssd_core.sv =====
// ----------------------------------------------------------------------------
// tb_residual_reconstruct_ssd_core: self-checking bench for the SSD core
// Drives column beats through the core under random gaps and back-pressure,
// predicts each result beat with a behavioural model of the reconstruction,
// the per-half error sums and the row and column counters, and compares every
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_residual_reconstruct_ssd_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rrs_pkg::*;

	// Random part length, settling time at the end and the run limit. The limit allows
	// for every beat meeting the longest gap on both sides, several times over.
	localparam int RandomBeats = 1250;
	localparam int SettleCycles = 10;
	localparam realtime RunLimit = 20ms;

	// Last row index of a block, for the normal and the short row table.
	localparam logic [4:0] ROWS_NORMAL [4] = '{5'd31, 5'd7, 5'd1, 5'd0};
	localparam logic [4:0] ROWS_SHORT [4]  = '{5'd15, 5'd3, 5'd0, 5'd0};

	localparam logic [1:0] SIZE_LARGEST  = 2'd0;
	localparam logic [1:0] SIZE_SMALLEST = 2'd3;
	localparam logic [2:0] DEPTH_PLAIN   = 3'd0;
	localparam logic [2:0] DEPTH_TOP     = 3'd7;
	localparam logic [1:0] COLOR_CHROMA  = 2'd1;

	// One input beat: a column of the lower and the upper half.
	typedef struct {
		logic signed [15:0] resid_lo;
		logic signed [15:0] resid_hi;
		logic [7:0]         pred_lo;
		logic [7:0]         pred_hi;
		logic [7:0]         ref_lo;
		logic [7:0]         ref_hi;
	} column_beat_t;

	// One result beat as the core should return it.
	typedef struct {
		logic [7:0]        rec_lo;
		logic [7:0]        rec_hi;
		logic [SumW-1:0]   ssd_lo;
		logic [SumW-1:0]   ssd_hi;
		logic [TotalW-1:0] ssd_total;
		logic              block_done;
	} recon_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [2:0] cfg_data;

	rrs_in_if  in_ch ();
	rrs_out_if out_ch ();

	residual_reconstruct_ssd_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in        (in_ch),
		.out       (out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the configuration registers and of the block state, kept in
	// step with the core by watching the write port and the accepted beats.
	logic [1:0]      shadow_color;
	logic [2:0]      shadow_depth;
	logic [1:0]      shadow_size;
	logic [4:0]      row_idx;
	logic [3:0]      col_idx;
	logic [SumW-1:0] err_sum_lo;
	logic [SumW-1:0] err_sum_hi;

	recon_result_t pending_results [$];
	int            fail_count = 0;

	// Idling controls shared between the test tasks and the two drivers.
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int rx_hold_cycles = 0;

	// Mostly no gap, sometimes a short one, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end else begin
			return $urandom_range(20, 60);
		end
	endfunction

	function automatic logic [7:0] clip_pixel(logic signed [15:0] resid, logic [7:0] pred);
		int s;
		s = int'(resid) + int'(pred);
		if (s < 0) begin
			return 8'd0;
		end else if (s > 255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

	function automatic int pixel_sq_err(logic [7:0] orig, logic [7:0] rec);
		int d;
		d = int'(orig) - int'(rec);
		return d * d;
	endfunction

	// Works out the result of one accepted beat and advances the block state.
	function automatic recon_result_t predict_recon(column_beat_t b);
		recon_result_t r;
		logic [7:0]    pred_up;
		logic [7:0]    ref_up;
		logic [4:0]    last_row;
		logic          row_end;

		pred_up = b.pred_hi;
		ref_up  = b.ref_hi;
		// Transform skip: the upper half reuses the lower half's pixels.
		if (shadow_color == COLOR_LUMA && shadow_depth == DEPTH_TSKIP) begin
			pred_up = b.pred_lo;
			ref_up  = b.ref_lo;
		end
		r.rec_lo = clip_pixel(b.resid_lo, b.pred_lo);
		r.rec_hi = clip_pixel(b.resid_hi, pred_up);
		err_sum_lo = err_sum_lo + SumW'(pixel_sq_err(b.ref_lo, r.rec_lo));
		err_sum_hi = err_sum_hi + SumW'(pixel_sq_err(ref_up, r.rec_hi));
		r.ssd_lo = err_sum_lo;
		r.ssd_hi = err_sum_hi;
		r.ssd_total = {1'b0, err_sum_lo} + {1'b0, err_sum_hi};

		last_row = (shadow_color == COLOR_SHORT) ? ROWS_SHORT[shadow_size]
			: ROWS_NORMAL[shadow_size];
		row_end = (col_idx >= 4'(ColumnsPerHalf - 1));
		r.block_done = row_end && (row_idx >= last_row);

		if (r.block_done) begin
			row_idx = '0;
			col_idx = '0;
			err_sum_lo = '0;
			err_sum_hi = '0;
		end else if (row_end) begin
			col_idx = '0;
			row_idx = row_idx + 5'd1;
		end else begin
			col_idx = col_idx + 4'd1;
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			fail_count++;
		end
	endtask

	// Result beats are checked before the beat accepted at the same edge is
	// predicted, so a result can never be matched against its own input.
	always @(posedge clk) begin : track_core
		recon_result_t e;
		column_beat_t  b;

		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no prediction waiting");
					fail_count++;
				end else begin
					e = pending_results.pop_front();
					check_field("rec_lo", e.rec_lo, out_ch.rec_lo);
					check_field("rec_hi", e.rec_hi, out_ch.rec_hi);
					check_field("ssd_lo", e.ssd_lo, out_ch.ssd_lo);
					check_field("ssd_hi", e.ssd_hi, out_ch.ssd_hi);
					check_field("ssd_total", e.ssd_total, out_ch.ssd_total);
					check_field("block_done", e.block_done, out_ch.block_done);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_COLOR: shadow_color = cfg_data[1:0];
					REG_DEPTH: shadow_depth = cfg_data;
					REG_SIZE:  shadow_size  = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				b.resid_lo = in_ch.resid_lo;
				b.resid_hi = in_ch.resid_hi;
				b.pred_lo  = in_ch.pred_lo;
				b.pred_hi  = in_ch.pred_hi;
				b.ref_lo   = in_ch.ref_lo;
				b.ref_hi   = in_ch.ref_hi;
				pending_results.push_back(predict_recon(b));
			end
		end
	end

	// Result side: random stalls, or a long hold-off when a test asks for
	// one. Each pass makes at most one assignment to ready per clock edge.
	initial begin : drive_ready
		int n;

		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = rx_gaps_on ? pick_gap() : 0;
				if (n > 0) begin
					out_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Residuals are mostly small, as a real transform would give, so that the
	// clipping is not the rule; a share spans the whole 16-bit range.
	function automatic column_beat_t make_beat();
		column_beat_t b;
		int           r;

		r = $urandom_range(0, 99);
		if (r < 70) begin
			b.resid_lo = 16'($urandom_range(0, 600)) - 16'sd300;
			b.resid_hi = 16'($urandom_range(0, 600)) - 16'sd300;
		end else if (r < 85) begin
			b.resid_lo = 16'($urandom_range(0, 8192)) - 16'sd4096;
			b.resid_hi = 16'($urandom_range(0, 8192)) - 16'sd4096;
		end else begin
			b.resid_lo = 16'($urandom);
			b.resid_hi = 16'($urandom);
		end
		b.pred_lo = 8'($urandom_range(0, 255));
		b.pred_hi = 8'($urandom_range(0, 255));
		b.ref_lo  = 8'($urandom_range(0, 255));
		b.ref_hi  = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic column_beat_t pack_beat(int rl, int rh, int pl, int ph, int ol, int oh);
		column_beat_t b;
		b.resid_lo = 16'(rl);
		b.resid_hi = 16'(rh);
		b.pred_lo  = 8'(pl);
		b.pred_hi  = 8'(ph);
		b.ref_lo   = 8'(ol);
		b.ref_hi   = 8'(oh);
		return b;
	endfunction

	// Offers one beat and returns at the edge where it is taken. Valid is
	// left high, so back-to-back beats never drop it within one time step;
	// only a gap before the next beat, or an explicit stop, lowers it.
	task automatic send_beat(column_beat_t b);
		int gap;

		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.resid_lo <= b.resid_lo;
		in_ch.resid_hi <= b.resid_hi;
		in_ch.pred_lo  <= b.pred_lo;
		in_ch.pred_hi  <= b.pred_hi;
		in_ch.ref_lo   <= b.ref_lo;
		in_ch.ref_hi   <= b.ref_hi;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// The sender goes quiet until every predicted result has come back. With
	// one result per beat the core is then empty and may be reconfigured.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Writes all three registers on consecutive edges; the enable stays high
	// throughout and drops once at the end.
	task automatic write_cfg(logic [1:0] color, logic [2:0] depth, logic [1:0] size);
		cfg_we    <= 1'b1;
		cfg_index <= REG_COLOR;
		cfg_data  <= {1'b0, color};
		@(posedge clk);
		cfg_index <= REG_DEPTH;
		cfg_data  <= depth;
		@(posedge clk);
		cfg_index <= REG_SIZE;
		cfg_data  <= {1'b0, size};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Field extremes and both clipping limits within a single one-row block,
	// so the sixteenth beat also closes the block.
	task automatic test_field_extremes();
		drain_results();
		write_cfg(COLOR_LUMA, DEPTH_PLAIN, SIZE_SMALLEST);
		send_beat(pack_beat(-32768, 32767, 0, 255, 0, 255));
		send_beat(pack_beat(32767, -32768, 255, 0, 0, 255));
		send_beat(pack_beat(0, 0, 0, 0, 0, 0));
		send_beat(pack_beat(-1, -1, 0, 255, 255, 0));
		send_beat(pack_beat(255, -255, 0, 255, 0, 255));
		send_beat(pack_beat(256, -256, 0, 255, 128, 127));
		send_beat(pack_beat(-256, 256, 255, 0, 255, 255));
		send_beat(pack_beat(1, -1, 254, 1, 255, 0));
		// Alternating bit patterns take every field bit to both values.
		send_beat(pack_beat(16'h5555, 16'hAAAA, 8'hAA, 8'h55, 8'h55, 8'hAA));
		send_beat(pack_beat(16'hAAAA, 16'h5555, 8'h55, 8'hAA, 8'hAA, 8'h55));
		repeat (6) send_beat(make_beat());
	endtask

	// Transform skip: the upper half must follow pred_lo and ref_lo, whatever
	// the upper pixels say.
	task automatic test_transform_skip();
		drain_results();
		write_cfg(COLOR_LUMA, DEPTH_TSKIP, SIZE_SMALLEST);
		send_beat(pack_beat(10, -10, 100, 0, 120, 255));
		send_beat(pack_beat(-5, 300, 200, 255, 0, 0));
		send_beat(pack_beat(0, 0, 255, 0, 0, 255));
		repeat (3) send_beat(make_beat());
	endtask

	// A block of the largest table entry is begun and, part way into its
	// second row, the size is cut to one row: the block must end with that row.
	task automatic test_mid_block_reconfig();
		drain_results();
		write_cfg(COLOR_LUMA, DEPTH_PLAIN, SIZE_LARGEST);
		repeat (20) send_beat(make_beat());
		drain_results();
		write_cfg(COLOR_SHORT, DEPTH_TOP, SIZE_SMALLEST);
		repeat (16) send_beat(make_beat());
	endtask

	// The receiver holds off for a long stretch while beats keep coming, so
	// the core fills and must stall its input.
	task automatic test_backpressure();
		drain_results();
		write_cfg(COLOR_CHROMA, DEPTH_TSKIP, 2'd2);
		tx_gaps_on = 1'b0;
		rx_hold_cycles = 300;
		repeat (64) send_beat(make_beat());
		tx_gaps_on = 1'b1;
		drain_results();
	endtask

	// One whole 32-row block with the worst error on every pixel brings both
	// sums to their largest values.
	task automatic test_largest_block();
		int n;

		drain_results();
		// First close whatever block is open, using a one-row limit.
		write_cfg(COLOR_LUMA, DEPTH_PLAIN, SIZE_SMALLEST);
		n = (row_idx == '0 && col_idx == '0) ? 0 : ColumnsPerHalf - int'(col_idx);
		repeat (n) send_beat(make_beat());
		drain_results();
		write_cfg(COLOR_LUMA, DEPTH_PLAIN, SIZE_LARGEST);
		repeat (MaxRows * ColumnsPerHalf) send_beat(pack_beat(32767, -32768, 255, 0, 0, 255));
	endtask

	// Random phases: each one drains, picks a fresh configuration and idling
	// style, and sends a run of beats that need not line up with blocks, so
	// size changes in mid block come up often. Small sizes dominate.
	task automatic test_random_stream();
		int         sent;
		int         n;
		int         r;
		logic [1:0] size;
		logic [2:0] depth;

		sent = 0;
		while (sent < RandomBeats) begin
			drain_results();
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			size = (r < 40) ? 2'd3 : (r < 75) ? 2'd2 : (r < 93) ? 2'd1 : 2'd0;
			depth = $urandom_range(0, 1) ? DEPTH_TSKIP : 3'($urandom_range(0, 7));
			write_cfg(2'($urandom_range(0, 3)), depth, size);
			n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 48) : $urandom_range(49, 160);
			repeat (n) send_beat(make_beat());
			sent += n;
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	initial begin
		shadow_color = COLOR_LUMA;
		shadow_depth = DEPTH_PLAIN;
		shadow_size  = SIZE_LARGEST;
		row_idx      = '0;
		col_idx      = '0;
		err_sum_lo   = '0;
		err_sum_hi   = '0;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_COLOR;
		cfg_data       <= '0;
		in_ch.valid    <= 1'b0;
		in_ch.resid_lo <= '0;
		in_ch.resid_hi <= '0;
		in_ch.pred_lo  <= '0;
		in_ch.pred_hi  <= '0;
		in_ch.ref_lo   <= '0;
		in_ch.ref_hi   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_transform_skip();
		test_mid_block_reconfig();
		test_backpressure();
		test_largest_block();
		test_random_stream();

		// Let every outstanding result arrive, then wait out the settling time,
		// in which any stray beat would be caught.
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("residual_reconstruct_ssd_core: match");
		end else begin
			$display("residual_reconstruct_ssd_core: mismatch");
		end
		$finish;
	end

	// A hang anywhere, such as a beat never accepted or a result never
	// returned, ends the run here.
	initial begin
		#(RunLimit);
		$display("residual_reconstruct_ssd_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rrs_pkg.sv
src/rrs_in_if.sv
src/rrs_out_if.sv
src/rrs_recon.sv
src/rrs_accum.sv
src/residual_reconstruct_ssd_core.sv
test/tb_residual_reconstruct_ssd_core.sv
